@@ hdl/hmbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmbp_pkg - shared constants and types of the message block padder
// Holds the store geometry, the pad byte codes, the register indexes and the
// block description handed from the controller to the word composer.
// ----------------------------------------------------------------------------
package hmbp_pkg;

	localparam int STORE_BYTES = 128;
	localparam int LANES       = 8;
	localparam int WORD_W      = 64;
	localparam int STORE_WORDS = STORE_BYTES / LANES;
	localparam int WADDR_W     = $clog2(STORE_WORDS);
	// block positions cover the largest block of 128 bytes
	localparam int BPOS_W      = 7;
	localparam bit WIDE_OK     = (STORE_BYTES >= 128);

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [7:0] PAD_MARK_BYTE = 8'h81;
	localparam logic [7:0] MARK_BYTE     = 8'h01;

	typedef enum logic [2:0] {
		CFG_BLOCK_SIZE   = 3'd0,
		CFG_LENGTH_WIDTH = 3'd1,
		CFG_COUNT_BLOCKS = 3'd2,
		CFG_LITTLE_END   = 3'd3,
		CFG_MARKER       = 3'd4,
		CFG_EXTRA_BLOCK  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LW_8  = 2'd0,
		LW_16 = 2'd1
	} len_width_t;

	// Description of the block being emitted.
	typedef struct packed {
		logic [BPOS_W:0]   mem_lim;    // bytes below this come from the store
		logic              pad_en;     // pad byte present
		logic              pad_mark;   // pad byte doubles as marker (0x81)
		logic [BPOS_W-1:0] pad_pos;
		logic              mark_en;    // 0x01 just before the length field
		logic              len_en;     // length field present
		logic              holds;      // block carries message bytes
		logic              len128;     // 128-byte block
		logic              little_end;
		logic [BPOS_W-1:0] len_idx;    // first byte of the length field
	} blk_t;

endpackage
`default_nettype wire

@@ hdl/hmbp_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmbp_store - block buffer memory
// Word-wide synchronous memory with byte lane enables and a registered read
// port; lane 0 sits in the most significant byte of a word.
// ----------------------------------------------------------------------------
module hmbp_store
	import hmbp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [WADDR_W-1:0]  waddr,
	input  wire logic [LANES-1:0]    wbe,
	input  wire logic [WORD_W-1:0]   wdata,
	input  wire logic                re,
	input  wire logic [WADDR_W-1:0]  raddr,
	output logic      [WORD_W-1:0]   rdata
);

	logic [WORD_W-1:0] mem_q [STORE_WORDS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int l = 0; l < LANES; l++) begin
				if (wbe[l]) begin
					mem_q[waddr][(LANES-1-l)*8 +: 8] <= wdata[(LANES-1-l)*8 +: 8];
				end
			end
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hdl/hmbp_compose.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmbp_compose - padded block word builder
// Builds one output word from the stored word and the block description:
// message bytes, pad byte, marker byte, length field bytes or zero.
// ----------------------------------------------------------------------------
module hmbp_compose
	import hmbp_pkg::*;
(
	input  wire logic [WORD_W-1:0]  rdata,
	input  wire logic [WADDR_W-1:0] widx,
	input  wire blk_t               blk,
	input  wire logic [63:0]        lenv,
	output logic      [WORD_W-1:0]  word
);

	always_comb begin
		logic [BPOS_W-1:0] p;
		logic [BPOS_W-1:0] last_p;
		logic [BPOS_W-1:0] off_le;
		logic [BPOS_W-1:0] off_be;
		logic              in_le;
		logic              in_be;
		logic [7:0]        b;
		word   = '0;
		last_p = {blk.len128, 6'h3F};
		for (int l = 0; l < LANES; l++) begin
			p      = {widx, 3'(l)};
			off_le = p - blk.len_idx;
			off_be = last_p - p;
			in_le  = (p >= blk.len_idx) && (off_le < BPOS_W'(8));
			in_be  = (off_be < BPOS_W'(8));
			if ({1'b0, p} < blk.mem_lim) begin
				b = rdata[(LANES-1-l)*8 +: 8];
			end else if (blk.pad_en && (p == blk.pad_pos)) begin
				b = blk.pad_mark ? PAD_MARK_BYTE : PAD_BYTE;
			end else if (blk.mark_en && (p == blk.len_idx - BPOS_W'(1))) begin
				b = MARK_BYTE;
			end else if (blk.len_en && blk.little_end && in_le) begin
				b = lenv[{off_le[2:0], 3'b000} +: 8];
			end else if (blk.len_en && !blk.little_end && in_be) begin
				b = lenv[{off_be[2:0], 3'b000} +: 8];
			end else begin
				b = 8'h00;
			end
			word[(LANES-1-l)*8 +: 8] = b;
		end
	end

endmodule
`default_nettype wire

@@ hdl/hash_message_block_padder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hash_message_block_padder - Merkle-Damgard message block padder
// Collects message bytes into 64- or 128-byte blocks in a word memory and
// emits full and padded blocks as 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (req_type, data_byte) enter on in_valid / in_stall. A message
//   byte is written into the block memory; the byte that fills a block
//   starts its emission. A finalize item passes through ST_PREP to work out
//   the padding layout and the length value, then emits one or two blocks.
//   Result items leave on out_valid / out_stall, one 64-bit word per cycle
//   while the receiver keeps up, read from the memory port and patched on
//   the fly with pad, marker and length bytes.
//   The first word of a block passes the memory read register and the word
//   register after the filling byte is accepted, after ST_PREP for a finalize
//   item; a byte that fills no block leaves the input ready for the next item.
//   The one-port read path of the memory sets the pace of one word a cycle.
//   in_stall is high while a block is being emitted or padding is prepared.
//   A stall on the output holds the word register and pauses memory reads.
//   Reset clears the byte count, the configuration registers and the control
//   state; the block memory is not cleared, so there is no start-up pass.
//   Configuration writes are taken at any time and must be made while idle.
// ----------------------------------------------------------------------------
module hash_message_block_padder
	import hmbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  data_byte,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      block_word,
	output logic [3:0]       word_index,
	output logic             last_word_of_block,
	output logic             block_holds_data,
	output logic             last_of_run,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic       bs_q;
	logic [1:0] lws_q;
	logic       cnt_mode_q;
	logic       le_q;
	logic       mark_q;
	logic       extra_q;

	logic [63:0]        byte_count_q;
	blk_t               blk_q;
	logic [63:0]        lenv_q;
	logic               two_q;     // a further block follows the current one
	logic [WADDR_W-1:0] w_q;
	logic               rdv_q;     // read data holds word w_q

	logic               out_valid_q;
	logic [WORD_W-1:0]  word_q;
	logic [3:0]         widx_q;
	logic               lwob_q;
	logic               holds_q;
	logic               lor_q;

	// ------------------------------------------------------------------
	// Block geometry and padding layout
	// ------------------------------------------------------------------
	logic              len128;
	logic [BPOS_W:0]   len_v;
	logic [5:0]        lw_bytes;
	logic [BPOS_W:0]   li8;
	logic [BPOS_W-1:0] li;
	logic [BPOS_W-1:0] pos;
	logic [BPOS_W-1:0] blk_last_pos;
	logic [BPOS_W-1:0] limit;
	logic              coincide;
	logic              ovf;
	logic              two;
	logic [63:0]       blkcnt;
	logic [63:0]       lenv_next;
	logic [1:0]        inc;

	assign len128       = bs_q & WIDE_OK;
	assign len_v        = len128 ? (BPOS_W+1)'(128) : (BPOS_W+1)'(64);
	assign blk_last_pos = {len128, 6'h3F};
	assign pos          = byte_count_q[BPOS_W-1:0] & blk_last_pos;

	always_comb begin
		case (lws_q)
			LW_8:    lw_bytes = 6'd8;
			LW_16:   lw_bytes = 6'd16;
			default: lw_bytes = 6'd32;  // unused code acts as 32 bytes
		endcase
	end

	assign li8   = len_v - {2'b00, lw_bytes};
	assign li    = li8[BPOS_W-1:0];
	assign limit = mark_q ? (li - BPOS_W'(1)) : li;

	// pad byte lands on the marker slot: merge into 0x81, one block
	assign coincide = mark_q && !extra_q && (pos == li - BPOS_W'(1));
	// pad (and marker) do not fit before the length field
	assign ovf      = ({1'b0, pos} + (BPOS_W+1)'(1)) > {1'b0, limit};
	assign two      = !coincide && (ovf || extra_q);

	// block count gains one more when the pad spills into an extra block
	assign inc       = (!coincide && ovf) ? 2'd2 : 2'd1;
	assign blkcnt    = len128 ? (byte_count_q >> 7) : (byte_count_q >> 6);
	assign lenv_next = cnt_mode_q ? (blkcnt + {62'd0, inc}) : {byte_count_q[60:0], 3'b000};

	// ------------------------------------------------------------------
	// Handshakes and emission control
	// ------------------------------------------------------------------
	logic               in_acc;
	logic               out_free;
	logic               emit_fire;
	logic [WADDR_W-1:0] words_last;
	logic               last_word;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign emit_fire  = (state_q == ST_EMIT) && rdv_q && out_free;
	assign words_last = len128 ? WADDR_W'(15) : WADDR_W'(7);
	assign last_word  = (w_q == words_last);

	// ------------------------------------------------------------------
	// Block memory: byte writes while idle, word write-back on emission
	// ------------------------------------------------------------------
	logic               mem_we;
	logic [WADDR_W-1:0] mem_waddr;
	logic [LANES-1:0]   mem_wbe;
	logic [WORD_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [WADDR_W-1:0] mem_raddr;
	logic [WORD_W-1:0]  mem_rdata;
	logic [WORD_W-1:0]  comp_word;
	logic               byte_wr;

	assign byte_wr   = in_acc && !req_type;
	assign mem_we    = byte_wr || emit_fire;
	assign mem_waddr = (state_q == ST_IDLE) ? pos[BPOS_W-1:3] : w_q;
	assign mem_wbe   = (state_q == ST_IDLE) ? (LANES'(1) << pos[2:0]) : {LANES{1'b1}};
	assign mem_wdata = (state_q == ST_IDLE) ? {LANES{data_byte}} : comp_word;

	// read the current word first, then one ahead of each emitted word
	assign mem_re    = (state_q == ST_EMIT) &&
	                   (!rdv_q || (emit_fire && !(last_word && !two_q)));
	assign mem_raddr = !rdv_q ? w_q : (last_word ? '0 : w_q + WADDR_W'(1));

	hmbp_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wbe   (mem_wbe),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hmbp_compose u_compose (
		.rdata (mem_rdata),
		.widx  (w_q),
		.blk   (blk_q),
		.lenv  (lenv_q),
		.word  (comp_word)
	);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q       <= 1'b0;
			lws_q      <= 2'd0;
			cnt_mode_q <= 1'b0;
			le_q       <= 1'b0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_SIZE:   bs_q       <= cfg_data[0];
				CFG_LENGTH_WIDTH: lws_q      <= cfg_data;
				CFG_COUNT_BLOCKS: cnt_mode_q <= cfg_data[0];
				CFG_LITTLE_END:   le_q       <= cfg_data[0];
				CFG_MARKER:       mark_q     <= cfg_data[0];
				CFG_EXTRA_BLOCK:  extra_q    <= cfg_data[0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_count_q <= '0;
			two_q        <= 1'b0;
			w_q          <= '0;
			rdv_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type) begin
							state_q <= ST_PREP;
						end else begin
							byte_count_q <= byte_count_q + 64'd1;
							// the filling byte starts emission of the block
							if (pos == blk_last_pos) begin
								two_q   <= 1'b0;
								w_q     <= '0;
								rdv_q   <= 1'b0;
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_PREP: begin
					byte_count_q <= '0;
					two_q        <= two;
					w_q          <= '0;
					rdv_q        <= 1'b0;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rdv_q) begin
						rdv_q <= 1'b1;
					end else if (out_free) begin
						if (last_word) begin
							if (two_q) begin
								two_q <= 1'b0;
								w_q   <= '0;
							end else begin
								rdv_q   <= 1'b0;
								state_q <= ST_IDLE;
							end
						end else begin
							w_q <= w_q + WADDR_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Block description, length value and output word register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && byte_wr) begin
			// a full block straight from the store
			blk_q.mem_lim    <= len_v;
			blk_q.pad_en     <= 1'b0;
			blk_q.pad_mark   <= 1'b0;
			blk_q.pad_pos    <= '0;
			blk_q.mark_en    <= 1'b0;
			blk_q.len_en     <= 1'b0;
			blk_q.holds      <= 1'b1;
			blk_q.len128     <= len128;
			blk_q.little_end <= le_q;
			blk_q.len_idx    <= li;
		end else if (state_q == ST_PREP) begin
			// first padded block: message bytes, the pad byte and, if it is the only one, marker and length
			blk_q.mem_lim    <= {1'b0, pos};
			blk_q.pad_en     <= 1'b1;
			blk_q.pad_mark   <= coincide;
			blk_q.pad_pos    <= pos;
			blk_q.mark_en    <= mark_q && !two && !coincide;
			blk_q.len_en     <= !two;
			blk_q.holds      <= (pos != '0);
			blk_q.len128     <= len128;
			blk_q.little_end <= le_q;
			blk_q.len_idx    <= li;
			lenv_q           <= lenv_next;
		end else if (emit_fire && last_word && two_q) begin
			// closing block: zeros, marker and length only
			blk_q.mem_lim <= '0;
			blk_q.pad_en  <= 1'b0;
			blk_q.mark_en <= mark_q;
			blk_q.len_en  <= 1'b1;
			blk_q.holds   <= 1'b0;
		end
		if (emit_fire) begin
			word_q  <= comp_word;
			widx_q  <= 4'(w_q);
			lwob_q  <= last_word;
			holds_q <= blk_q.holds;
			lor_q   <= last_word && !two_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign block_word         = word_q;
	assign word_index         = widx_q;
	assign last_word_of_block = lwob_q;
	assign block_holds_data   = holds_q;
	assign last_of_run        = lor_q;

`ifndef SYNTH
	a_run_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> last_word_of_block)
		else $error("run ended inside a block");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_PREP) |-> (byte_count_q == '0))
		else $error("byte count not cleared after finalize");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rdv_q && !two_q))
		else $error("emission state left over while idle");

	a_block_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word_of_block |-> (word_index == 4'd7 || word_index == 4'd15))
		else $error("block ended at a wrong word index");
`endif

endmodule
`default_nettype wire
